// File: rtl/core/sled_pkg.sv
`timescale 1ns / 1ps
// Package for the string literal escape decoder: item and result types,
// decoder modes, character constants and the escape and hex lookup functions.
// Depends on nothing; every other file of the block but sled_if uses it.

package sled_pkg;

  // Character codes recognized by the decoder.
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LB     = 8'h62;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_LN     = 8'h6E;
  localparam logic [7:0] CH_LR     = 8'h72;
  localparam logic [7:0] CH_LT     = 8'h74;
  localparam logic [7:0] CH_LV     = 8'h76;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;

  // Decoded values of the control escapes.
  localparam logic [7:0] VAL_NUL = 8'd0;
  localparam logic [7:0] VAL_BEL = 8'd7;
  localparam logic [7:0] VAL_BS  = 8'd8;
  localparam logic [7:0] VAL_FF  = 8'd12;
  localparam logic [7:0] VAL_LF  = 8'd10;
  localparam logic [7:0] VAL_CR  = 8'd13;
  localparam logic [7:0] VAL_HT  = 8'd9;
  localparam logic [7:0] VAL_VT  = 8'd11;
  localparam logic [7:0] HEX_LETTER_BASE = 8'd10;

  // Error codes carried on a result item.
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_BAD_HEX = 2'd1;
  localparam logic [1:0] ERR_TRUNC   = 2'd2;

  // Decoder modes, one-hot.
  typedef enum logic [6:0] {
    MODE_OPEN     = 7'b0000001,
    MODE_BODY     = 7'b0000010,
    MODE_ESC      = 7'b0000100,
    MODE_HEX1     = 7'b0001000,
    MODE_HEX2     = 7'b0010000,
    MODE_HEX2_BAD = 7'b0100000,
    MODE_DISCARD  = 7'b1000000
  } mode_t;

  // One input item.
  typedef struct packed {
    logic [7:0] raw_char;
    logic       is_last;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       end_of_string;
    logic [1:0] error_code;
  } res_t;

  // What the decoder makes of the item it holds.
  typedef struct packed {
    logic has_result;
    res_t res;
  } dec_t;

  // Decoder status seen by the top level.
  typedef struct packed {
    mode_t mode;
  } dec_status_t;

  // Lookup result: a flag and a value.
  typedef struct packed {
    logic       ok;
    logic [7:0] val;
  } lookup_t;

  // Hex digit value of a character, upper or lower case.
  function automatic lookup_t hex_lookup(input logic [7:0] c);
    lookup_t r;
    r.ok  = 1'b0;
    r.val = 8'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      r.ok  = 1'b1;
      r.val = c - CH_ZERO;
    end else if (c >= CH_LA && c <= CH_LF) begin
      r.ok  = 1'b1;
      r.val = c - CH_LA + HEX_LETTER_BASE;
    end else if (c >= CH_UA && c <= CH_UF) begin
      r.ok  = 1'b1;
      r.val = c - CH_UA + HEX_LETTER_BASE;
    end
    return r;
  endfunction

  // Value of a known single-character escape.
  function automatic lookup_t esc_lookup(input logic [7:0] c);
    lookup_t r;
    r.ok  = 1'b1;
    r.val = 8'd0;
    unique case (c)
      CH_ZERO:   r.val = VAL_NUL;
      CH_LA:     r.val = VAL_BEL;
      CH_LB:     r.val = VAL_BS;
      CH_LF:     r.val = VAL_FF;
      CH_LN:     r.val = VAL_LF;
      CH_LR:     r.val = VAL_CR;
      CH_LT:     r.val = VAL_HT;
      CH_LV:     r.val = VAL_VT;
      CH_BSLASH: r.val = CH_BSLASH;
      CH_SQUOTE: r.val = CH_SQUOTE;
      CH_DQUOTE: r.val = CH_DQUOTE;
      default:   r.ok  = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/sled_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the string literal escape decoder:
// one for input items and one for result items. Depends on nothing.

// Input channel: one byte of the literal per item.
interface sled_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_char;
  logic       is_last;

  modport source (output valid, output raw_char, output is_last, input ready);
  modport sink   (input valid, input raw_char, input is_last, output ready);
endinterface

// Result channel: zero or one decoded byte per input item.
interface sled_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic       end_of_string;
  logic [1:0] error_code;

  modport source (output valid, output out_char, output char_valid,
                  output end_of_string, output error_code, input ready);
  modport sink   (input valid, input out_char, input char_valid,
                  input end_of_string, input error_code, output ready);
endinterface

// File: rtl/core/sled_in_reg.sv
`timescale 1ns / 1ps
// Input register of the string literal escape decoder.
// Depends on sled_pkg and sled_in_if.

module sled_in_reg (
  input  logic                  clk,
  input  logic                  rst_n,
  sled_in_if.sink               in_ch,
  input  logic                  advance,
  output logic                  item_valid,
  output sled_pkg::item_t       item
);

  logic            valid_r;
  logic            valid_nxt;
  sled_pkg::item_t item_r;
  logic            accept;

  // The register takes a new item when empty or when its item moves on.
  assign in_ch.ready = !valid_r || advance;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.raw_char <= in_ch.raw_char;
      item_r.is_last  <= in_ch.is_last;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// File: rtl/core/sled_decode.sv
`timescale 1ns / 1ps
// Escape decoder: mode and hex nibble registers and the per-item decision.
// Depends on sled_pkg.

module sled_decode (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sled_pkg::item_t       item,
  input  logic                  commit,
  output sled_pkg::dec_t        dec,
  output sled_pkg::dec_status_t status
);

  sled_pkg::mode_t   mode_r;
  sled_pkg::mode_t   mode_nxt;
  logic [3:0]        nib_r;
  logic [3:0]        nib_nxt;
  sled_pkg::lookup_t hex;
  sled_pkg::lookup_t esc;
  logic [7:0]        c;
  logic              last;

  assign c    = item.raw_char;
  assign last = item.is_last;
  assign hex  = sled_pkg::hex_lookup(c);
  assign esc  = sled_pkg::esc_lookup(c);

  // Next mode and the result, if any, for the item held in the input register.
  always_comb begin
    mode_nxt                    = mode_r;
    nib_nxt                     = nib_r;
    dec.has_result              = 1'b0;
    dec.res.out_char            = 8'd0;
    dec.res.char_valid          = 1'b0;
    dec.res.end_of_string       = 1'b0;
    dec.res.error_code          = sled_pkg::ERR_NONE;

    if (last) begin
      // The closing byte always ends the literal with one result.
      mode_nxt              = sled_pkg::MODE_OPEN;
      nib_nxt               = 4'd0;
      dec.has_result        = 1'b1;
      dec.res.end_of_string = 1'b1;
    end

    unique case (mode_r) inside
      sled_pkg::MODE_BODY: begin
        if (!last) begin
          if (c == sled_pkg::CH_BSLASH) begin
            mode_nxt = sled_pkg::MODE_ESC;
          end else begin
            dec.has_result     = 1'b1;
            dec.res.out_char   = c;
            dec.res.char_valid = 1'b1;
          end
        end
      end

      sled_pkg::MODE_ESC: begin
        if (c == sled_pkg::CH_X) begin
          if (last) begin
            dec.res.error_code = sled_pkg::ERR_TRUNC;
          end else begin
            mode_nxt = sled_pkg::MODE_HEX1;
          end
        end else begin
          if (!last) begin
            mode_nxt = sled_pkg::MODE_BODY;
          end
          if (esc.ok) begin
            dec.has_result     = 1'b1;
            dec.res.out_char   = esc.val;
            dec.res.char_valid = 1'b1;
          end
        end
      end

      sled_pkg::MODE_HEX1: begin
        if (last) begin
          dec.res.error_code = sled_pkg::ERR_TRUNC;
        end else if (hex.ok) begin
          nib_nxt  = hex.val[3:0];
          mode_nxt = sled_pkg::MODE_HEX2;
        end else begin
          nib_nxt  = 4'd0;
          mode_nxt = sled_pkg::MODE_HEX2_BAD;
        end
      end

      sled_pkg::MODE_HEX2, sled_pkg::MODE_HEX2_BAD: begin
        nib_nxt        = 4'd0;
        dec.has_result = 1'b1;
        if (last) begin
          dec.res.error_code = sled_pkg::ERR_TRUNC;
        end else if (mode_r == sled_pkg::MODE_HEX2 && hex.ok) begin
          dec.res.out_char   = {nib_r, hex.val[3:0]};
          dec.res.char_valid = 1'b1;
          mode_nxt           = sled_pkg::MODE_BODY;
        end else begin
          dec.res.error_code = sled_pkg::ERR_BAD_HEX;
          mode_nxt           = sled_pkg::MODE_DISCARD;
        end
      end

      sled_pkg::MODE_DISCARD: begin
        // Bytes after a bad hex escape are dropped until the closing byte.
      end

      default: begin
        // Open mode: the opening byte is dropped.
        if (!last) begin
          mode_nxt = sled_pkg::MODE_BODY;
          nib_nxt  = 4'd0;
        end
      end
    endcase
  end

  // State moves only when the held item is consumed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= sled_pkg::MODE_OPEN;
      nib_r  <= 4'd0;
    end else if (commit) begin
      mode_r <= mode_nxt;
      nib_r  <= nib_nxt;
    end
  end

  assign status.mode = mode_r;

endmodule

// File: rtl/core/sled_out_reg.sv
`timescale 1ns / 1ps
// Result register of the string literal escape decoder.
// Depends on sled_pkg and sled_out_if.

module sled_out_reg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  sled_pkg::res_t        res,
  output logic                  free,
  sled_out_if.source            out_ch
);

  logic           valid_r;
  logic           valid_nxt;
  sled_pkg::res_t res_r;

  // The register can take a result when empty or when its result is taken now.
  assign free = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.out_char      = res_r.out_char;
  assign out_ch.char_valid    = res_r.char_valid;
  assign out_ch.end_of_string = res_r.end_of_string;
  assign out_ch.error_code    = res_r.error_code;

endmodule

// File: rtl/core/string_literal_escape_decoder.sv
`timescale 1ns / 1ps
// Top level of the string literal escape decoder: input register, decoder
// and result register. Depends on sled_pkg, sled_if and the sled_* modules.
//
//   channel   direction  handshake      payload
//   in_ch     in         valid / ready  raw_char[7:0], is_last
//   out_ch    out        valid / ready  out_char[7:0], char_valid,
//                                       end_of_string, error_code[1:0]
//
// One item per cycle sustained while the result register has room; a result
// passes through the input register and then the result register to out_ch.
// The mode register is updated once per consumed item.
// Reset is synchronous on rst_n and returns the decoder to the open mode.
// An item that gives no result moves on even while the result register is
// full; one that gives a result waits for room there.

module string_literal_escape_decoder (
  input  logic        clk,
  input  logic        rst_n,
  sled_in_if.sink     in_ch,
  sled_out_if.source  out_ch
);

  logic                  item_valid;
  sled_pkg::item_t       item;
  sled_pkg::dec_t        dec;
  sled_pkg::dec_status_t status;
  logic                  out_free;
  logic                  commit;

  // The held item is consumed when its result, if any, has room.
  assign commit = item_valid && (!dec.has_result || out_free);

  sled_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .advance    (commit),
    .item_valid (item_valid),
    .item       (item)
  );

  sled_decode u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .item   (item),
    .commit (commit),
    .dec    (dec),
    .status (status)
  );

  sled_out_reg u_out_reg (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (commit && dec.has_result),
    .res    (dec.res),
    .free   (out_free),
    .out_ch (out_ch)
  );

  // A result never carries both a byte and an error.
  a_byte_xor_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.char_valid && out_ch.error_code != sled_pkg::ERR_NONE))
    else $error("result carries both a byte and an error");

  // Closing a literal returns the decoder to the open mode.
  a_end_to_open: assert property (@(posedge clk) disable iff (!rst_n)
    commit && dec.has_result && dec.res.end_of_string
      |=> status.mode == sled_pkg::MODE_OPEN)
    else $error("decoder not in open mode after end of string");

  // A held item that does not move on stays held.
  a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid && !commit |=> item_valid && $stable(item))
    else $error("held input item lost or changed");

  // A result only appears through a load of the result register.
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(commit && dec.has_result))
    else $error("result appeared without a decoded item");

endmodule
